### design/apct_pkg.sv
// shared constants and request codes for the aabb pair collision tracker
package apct_pkg;

  localparam int DEF_MAX_OBJECTS = 8;
  localparam int DEF_COORD_BITS = 32;
  localparam int SLOT_W = 3;
  localparam int IN_COORD_W = 32;
  localparam int AXES = 3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SWEEP = 1'b1;

endpackage

### design/aabb_pair_collision_tracker_top.sv
// aabb pair collision tracker: box store, pair bitmap and sweep sequencer
//
// Input channel (in_valid / in_stall): a load transfer (req_type 0) writes one
// slot's box and takes-part flag; loads to slots at or beyond MAX_OBJECTS are
// dropped. A sweep transfer (req_type 1) walks all ordered pairs of distinct
// taking-part slots, row by row, and reports each pair that newly overlaps.
// Output channel (out_valid / out_stall): one transfer per new pair, the last
// one marked by last; a sweep with no new pair gives a single transfer with
// found = 0, both slots 0 and last = 1.
// One item is worked on at a time; in_stall is high while a sweep runs.
// During a sweep each taking-part row reads its pair row and its box, then
// steps through every slot, with a box read and compare for each tested pair;
// each box memory copy has one read port. Each new pair is held back until
// the next new pair or the end of the sweep, so the final one can carry last;
// when the receiver stalls, the sweep waits in front of the output register.
// Reset clears all take-part flags and the pair bitmap (per-row valid bits),
// the box memories stay undefined until written.
module aabb_pair_collision_tracker_top
  import apct_pkg::*;
#(
  parameter int MAX_OBJECTS = DEF_MAX_OBJECTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   req_type,
  input  logic [SLOT_W-1:0]      slot,
  input  logic                   takes_part,
  input  logic signed [IN_COORD_W-1:0] min_x,
  input  logic signed [IN_COORD_W-1:0] min_y,
  input  logic signed [IN_COORD_W-1:0] min_z,
  input  logic signed [IN_COORD_W-1:0] max_x,
  input  logic signed [IN_COORD_W-1:0] max_y,
  input  logic signed [IN_COORD_W-1:0] max_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  output logic [SLOT_W-1:0]      first_slot,
  output logic [SLOT_W-1:0]      second_slot,
  output logic                   last
);

  localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int BOX_W = 2 * AXES * COORD_BITS;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_OBJECTS - 1);
  localparam logic [SLOT_W:0] SlotLimit = (SLOT_W + 1)'(MAX_OBJECTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_LOADROW,
    ST_PAIR,
    ST_EVAL,
    ST_ROWEND,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [IDX_W-1:0]       a;
  logic [IDX_W-1:0]       b;
  logic [MAX_OBJECTS-1:0] slot_active;
  logic [MAX_OBJECTS-1:0] row_valid;
  logic [MAX_OBJECTS-1:0] row_bits;
  logic                   pend_valid;
  logic [IDX_W-1:0]       pend_first;
  logic [IDX_W-1:0]       pend_second;

  logic                   in_xfer;
  logic                   load_wr;
  logic [BOX_W-1:0]       box_wr;
  logic [BOX_W-1:0]       box_a;
  logic [BOX_W-1:0]       box_b;
  logic [MAX_OBJECTS-1:0] pair_rd;
  logic                   hit;
  logic                   out_free;
  logic                   out_load;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign load_wr = in_xfer && (req_type == REQ_LOAD) && ({1'b0, slot} < SlotLimit);
  assign out_free = !out_valid || !out_stall;

  // output register takes a new transfer this cycle
  assign out_load = ((state == ST_EVAL) && hit && !row_bits[b] && pend_valid && out_free) ||
                    ((state == ST_FINISH) && out_free);

  assign box_wr = {max_z[COORD_BITS-1:0], max_y[COORD_BITS-1:0], max_x[COORD_BITS-1:0],
                   min_z[COORD_BITS-1:0], min_y[COORD_BITS-1:0], min_x[COORD_BITS-1:0]};

  // two copies of the box store so both boxes of a pair read in the same cycle
  apct_ram #(
    .WIDTH(BOX_W),
    .DEPTH(MAX_OBJECTS)
  ) u_box_ram_a (
    .clk    (clk),
    .wr_en  (load_wr),
    .wr_addr(slot[IDX_W-1:0]),
    .wr_data(box_wr),
    .rd_addr(a),
    .rd_data(box_a)
  );

  apct_ram #(
    .WIDTH(BOX_W),
    .DEPTH(MAX_OBJECTS)
  ) u_box_ram_b (
    .clk    (clk),
    .wr_en  (load_wr),
    .wr_addr(slot[IDX_W-1:0]),
    .wr_data(box_wr),
    .rd_addr(b),
    .rd_data(box_b)
  );

  // pair bitmap, one row per first slot
  apct_ram #(
    .WIDTH(MAX_OBJECTS),
    .DEPTH(MAX_OBJECTS)
  ) u_pair_ram (
    .clk    (clk),
    .wr_en  (state == ST_ROWEND),
    .wr_addr(a),
    .wr_data(row_bits),
    .rd_addr(a),
    .rd_data(pair_rd)
  );

  apct_overlap #(
    .COORD_BITS(COORD_BITS)
  ) u_overlap (
    .box_a(box_a),
    .box_b(box_b),
    .hit  (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      a           <= '0;
      b           <= '0;
      slot_active <= '0;
      row_valid   <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (load_wr) begin
            slot_active[slot[IDX_W-1:0]] <= takes_part;
          end
          if (in_xfer && (req_type == REQ_SWEEP)) begin
            a          <= '0;
            pend_valid <= 1'b0;
            state      <= ST_ROW;
          end
        end
        ST_ROW: begin
          if (slot_active[a]) begin
            state <= ST_LOADROW;
          end else if (a == LastIdx) begin
            state <= ST_FINISH;
          end else begin
            a <= a + 1'b1;
          end
        end
        ST_LOADROW: begin
          row_bits <= row_valid[a] ? pair_rd : '0;
          b        <= '0;
          state    <= ST_PAIR;
        end
        ST_PAIR: begin
          if ((b == a) || !slot_active[b]) begin
            if (b == LastIdx) begin
              state <= ST_ROWEND;
            end else begin
              b <= b + 1'b1;
            end
          end else begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          // a new pair can only move on once the held-back one has a place
          if (!(hit && !row_bits[b] && pend_valid && !out_free)) begin
            row_bits[b] <= hit;
            if (hit && !row_bits[b]) begin
              if (pend_valid) begin
                out_valid   <= 1'b1;
                found       <= 1'b1;
                first_slot  <= SLOT_W'(pend_first);
                second_slot <= SLOT_W'(pend_second);
                last        <= 1'b0;
              end
              pend_valid  <= 1'b1;
              pend_first  <= a;
              pend_second <= b;
            end
            if (b == LastIdx) begin
              state <= ST_ROWEND;
            end else begin
              b     <= b + 1'b1;
              state <= ST_PAIR;
            end
          end
        end
        ST_ROWEND: begin
          row_valid[a] <= 1'b1;
          if (a == LastIdx) begin
            state <= ST_FINISH;
          end else begin
            a     <= a + 1'b1;
            state <= ST_ROW;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            found       <= pend_valid;
            first_slot  <= pend_valid ? SLOT_W'(pend_first) : '0;
            second_slot <= pend_valid ? SLOT_W'(pend_second) : '0;
            last        <= 1'b1;
            pend_valid  <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_eval_tested_pair: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> (a != b) && slot_active[a] && slot_active[b])
    else $error("pair evaluated with an excluded or equal slot");

  a_no_pending_when_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("held-back pair left over after sweep");

  a_empty_result_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last && (first_slot == '0) && (second_slot == '0))
    else $error("empty sweep result malformed");

  a_finish_pushes: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && out_free |=> out_valid && last)
    else $error("sweep ended without a terminating transfer");

endmodule

### design/apct_ram.sv
// generic single-port-write ram with registered read
module apct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/apct_overlap.sv
// closed-interval overlap test of two boxes on all axes
module apct_overlap
  import apct_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic [2*AXES*COORD_BITS-1:0] box_a,
  input  logic [2*AXES*COORD_BITS-1:0] box_b,
  output logic                         hit
);

  logic [AXES-1:0] axis_hit;

  // box layout: min corner in the low half, max corner in the high half
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      axis_hit[k] =
        ($signed(box_a[k*COORD_BITS +: COORD_BITS]) <=
         $signed(box_b[(AXES+k)*COORD_BITS +: COORD_BITS])) &&
        ($signed(box_a[(AXES+k)*COORD_BITS +: COORD_BITS]) >=
         $signed(box_b[k*COORD_BITS +: COORD_BITS]));
    end
  end

  assign hit = &axis_hit;

endmodule

### dv/tb.sv
// testbench for the aabb pair collision tracker: pair scoreboard, drivers and stimulus
`timescale 1ns / 100ps

module tb;
  import apct_pkg::*;

  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int COORD_SHIFT = IN_COORD_W - DEF_COORD_BITS;
  localparam logic signed [IN_COORD_W-1:0] MIN_C = 32'sh8000_0000;
  localparam logic signed [IN_COORD_W-1:0] MAX_C = 32'sh7fff_ffff;

  typedef struct {
    logic signed [IN_COORD_W-1:0] lo[AXES];
    logic signed [IN_COORD_W-1:0] hi[AXES];
  } box_t;

  typedef struct {
    logic              req;
    logic [SLOT_W-1:0] slot;
    logic              tp;
    box_t              box;
  } box_req_t;

  typedef struct {
    logic              found;
    logic [SLOT_W-1:0] first;
    logic [SLOT_W-1:0] second;
    logic              last;
  } pair_rpt_t;

  class pair_scoreboard;
    box_t        boxes[8];
    logic [7:0]  active;
    logic [63:0] colliding;
    pair_rpt_t   expected_pairs[$];
    int          mismatches;

    function new();
      active = '0;
      colliding = '0;
      mismatches = 0;
    endfunction

    function void expect_result(pair_rpt_t r);
      expected_pairs.insert(expected_pairs.size(), r);
    endfunction

    function bit overlap(int a, int b);
      for (int ax = 0; ax < AXES; ax++) begin
        if (boxes[a].lo[ax] > boxes[b].hi[ax] || boxes[a].hi[ax] < boxes[b].lo[ax]) return 0;
      end
      return 1;
    endfunction

    // accepted input transfer: loads update the store, sweeps predict the pair reports
    function void note_item(box_req_t it);
      pair_rpt_t held;
      bit        have_held;
      logic signed [IN_COORD_W-1:0] v;
      have_held = 0;
      if (it.req == REQ_LOAD) begin
        if (int'(it.slot) < DEF_MAX_OBJECTS) begin
          active[it.slot] = it.tp;
          for (int ax = 0; ax < AXES; ax++) begin
            v = it.box.lo[ax] <<< COORD_SHIFT;
            boxes[it.slot].lo[ax] = v >>> COORD_SHIFT;
            v = it.box.hi[ax] <<< COORD_SHIFT;
            boxes[it.slot].hi[ax] = v >>> COORD_SHIFT;
          end
        end
        return;
      end
      for (int a = 0; a < DEF_MAX_OBJECTS; a++) begin
        for (int b = 0; b < DEF_MAX_OBJECTS; b++) begin
          if (a != b && active[a] && active[b]) begin
            if (overlap(a, b)) begin
              if (!colliding[a*8+b]) begin
                colliding[a*8+b] = 1'b1;
                // hold each new pair back so the final one can carry last
                if (have_held) expect_result(held);
                held = '{1'b1, 3'(a), 3'(b), 1'b0};
                have_held = 1;
              end
            end else begin
              colliding[a*8+b] = 1'b0;
            end
          end
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        expect_result(held);
      end else begin
        expect_result('{1'b0, '0, '0, 1'b1});
      end
    endfunction

    function void check_pair(pair_rpt_t got);
      pair_rpt_t want;
      if (expected_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d first=%0d second=%0d last=%0d",
                   got.found, got.first, got.second, got.last);
        return;
      end
      want = expected_pairs.pop_front();
      if (got.found !== want.found || got.first !== want.first ||
          got.second !== want.second || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected found=%0d first=%0d second=%0d last=%0d,",
                    " got found=%0d first=%0d second=%0d last=%0d"},
                   want.found, want.first, want.second, want.last,
                   got.found, got.first, got.second, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = REQ_LOAD;
  logic [SLOT_W-1:0] slot = '0;
  logic takes_part = 1'b0;
  logic signed [IN_COORD_W-1:0] min_x = '0, min_y = '0, min_z = '0;
  logic signed [IN_COORD_W-1:0] max_x = '0, max_y = '0, max_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [SLOT_W-1:0] first_slot, second_slot;
  logic last;

  bit quiet = 0;
  pair_scoreboard tracker = new();

  aabb_pair_collision_tracker_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .slot(slot), .takes_part(takes_part),
    .min_x(min_x), .min_y(min_y), .min_z(min_z),
    .max_x(max_x), .max_y(max_y), .max_z(max_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .first_slot(first_slot), .second_slot(second_slot), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_pair('{found, first_slot, second_slot, last});
  end

  initial begin
    for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("** aabb_pair_collision_tracker_top: FAILED **");
    $finish;
  end

  function automatic box_t cube(int lo, int hi);
    box_t b;
    for (int ax = 0; ax < AXES; ax++) begin
      b.lo[ax] = lo;
      b.hi[ax] = hi;
    end
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send(input box_req_t it);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    req_type <= it.req;
    slot <= it.slot;
    takes_part <= it.tp;
    min_x <= it.box.lo[0];
    min_y <= it.box.lo[1];
    min_z <= it.box.lo[2];
    max_x <= it.box.hi[0];
    max_y <= it.box.hi[1];
    max_z <= it.box.hi[2];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_item(it);
    @(negedge clk);
  endtask

  task automatic load(input int s, input bit tp, input box_t b);
    box_req_t it;
    it.req = REQ_LOAD;
    it.slot = 3'(s);
    it.tp = tp;
    it.box = b;
    send(it);
  endtask

  // sweep with junk in the load-only fields
  task automatic sweep();
    box_req_t it;
    it.req = REQ_SWEEP;
    it.slot = 3'($urandom);
    it.tp = 1'($urandom);
    for (int ax = 0; ax < AXES; ax++) begin
      it.box.lo[ax] = $urandom;
      it.box.hi[ax] = $urandom;
    end
    send(it);
  endtask

  // sender goes quiet until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.expected_pairs.size() != 0) @(negedge clk);
  endtask

  initial begin
    box_t b;
    int   kind;
    int   mode;
    int   c;
    int   h;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // nothing active yet
    sweep();
    // full-range box plus nested boxes around the origin: every ordered pair is new
    b.lo = '{MIN_C, MIN_C, MIN_C};
    b.hi = '{MAX_C, MAX_C, MAX_C};
    load(0, 1'b1, b);
    for (int s = 1; s < 8; s++) load(s, 1'b1, cube(-s * ONE, s * ONE));
    sweep();
    sweep();
    // excluded slot keeps its pair bits, so coming back overlapping reports nothing
    load(1, 1'b0, cube(100 * ONE, 200 * ONE));
    sweep();
    load(1, 1'b1, cube(-ONE, ONE));
    sweep();
    // closed intervals: boxes that only touch on a face still collide
    load(2, 1'b1, cube(4 * ONE, 6 * ONE));
    sweep();
    load(3, 1'b1, cube(6 * ONE, 9 * ONE));
    sweep();
    // inverted box and single points at both coordinate extremes
    load(5, 1'b1, cube(3 * ONE, -3 * ONE));
    b.lo = '{MIN_C, MIN_C, MIN_C};
    b.hi = '{MIN_C, MIN_C, MIN_C};
    load(4, 1'b1, b);
    b.lo = '{MAX_C, MAX_C, MAX_C};
    b.hi = '{MAX_C, MAX_C, MAX_C};
    load(6, 1'b1, b);
    sweep();
    wait_drained();

    for (int i = 0; i < 220; i++) begin
      quiet = (i >= 60 && i < 120);
      if (i == 150) wait_drained();
      kind = $urandom_range(99);
      if (kind < 25) begin
        sweep();
      end else begin
        mode = $urandom_range(99);
        for (int ax = 0; ax < AXES; ax++) begin
          c = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
          h = int'($urandom_range(0, 3 * ONE));
          if (mode < 60) begin
            b.lo[ax] = c - h;
            b.hi[ax] = c + h;
          end else if (mode < 80) begin
            // whole units make exactly touching faces common
            c = (int'($urandom_range(0, 6)) - 3) * ONE;
            b.lo[ax] = c;
            b.hi[ax] = c + int'($urandom_range(0, 2)) * ONE;
          end else if (mode < 92) begin
            b.lo[ax] = $urandom;
            b.hi[ax] = $urandom;
          end else begin
            b.lo[ax] = c + h + 1;
            b.hi[ax] = c - h;
          end
        end
        load($urandom_range(7), $urandom_range(99) < 80, b);
      end
    end
    quiet = 0;

    wait_drained();
    repeat (200) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.expected_pairs.size() == 0) begin
      $display("** aabb_pair_collision_tracker_top: PASSED **");
    end else begin
      $display("** aabb_pair_collision_tracker_top: FAILED **");
    end
    $finish;
  end

endmodule
